/* rtl/mbts_pkg.sv */
package mbts_pkg;

    localparam int MAX_DIM  = 256;
    localparam int DIM_BITS = 8;          // coordinate width, log2(MAX_DIM)
    localparam int LEVELS   = 9;          // physical mip levels
    localparam int LV_W     = 4;
    localparam int TEXEL_W  = 32;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        CFG_BASE_W = 2'd0,
        CFG_BASE_H = 2'd1,
        CFG_COMP   = 2'd2,
        CFG_MIPS   = 2'd3
    } t_cfg_idx;

    // Each bank holds one quarter of every level (one texel of each 2x2 quad).
    function automatic int f_bank_depth();
        int acc;
        int h;
        acc = 0;
        for (int k = 0; k < LEVELS; k++) begin
            h = (MAX_DIM >> k) / 2;
            if (h < 1) h = 1;
            acc += h * h;
        end
        return acc;
    endfunction

    localparam int BANK_DEPTH = f_bank_depth();
    localparam int BA_W       = $clog2(BANK_DEPTH);

    typedef logic [BA_W-1:0] t_baddr;
    typedef t_baddr [LEVELS-1:0] t_off_tab;

    function automatic t_off_tab f_off_tab();
        t_off_tab t;
        int acc;
        int h;
        acc = 0;
        for (int k = 0; k < LEVELS; k++) begin
            t[k] = t_baddr'(acc);
            h = (MAX_DIM >> k) / 2;
            if (h < 1) h = 1;
            acc += h * h;
        end
        return t;
    endfunction

    localparam t_off_tab BANK_OFF = f_off_tab();

endpackage

/* rtl/mbts_ram.sv */
module mbts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

/* rtl/mipmapped_bilinear_texture_sampler_core.sv */
// Samples pass stages S, A, D, H and V to the level blend and output buffer; writes end at the banks.
// One beat per cycle for writes and one-level samples unless the output buffer is full; a sample
// of two levels holds the input for its second level; the four banks serve one 2x2 quad per cycle.
// Reset: i_rst_n is synchronous, active low; it clears the pipeline, the output buffer and the
// registers (width 1, height 1, four channels, no mips). Texel memory is not cleared.
module mipmapped_bilinear_texture_sampler_core
    import mbts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // level[3:0] tex_x[11:4] tex_y[19:12] texel_r[27:20] texel_g[35:28] texel_b[43:36]
    // texel_a[51:44] u_frac[67:52] v_frac[83:68] lod[95:84]
    input  logic [95:0] s_axis_tdata,
    // cmd[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // red[15:0] green[31:16] blue[47:32] alpha[63:48]
    output logic [63:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    // ---------------- configuration ----------------
    logic [8:0] r_base_w, r_base_h;
    logic [2:0] r_comp;
    logic [3:0] r_mips;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_w <= 9'd1;
            r_base_h <= 9'd1;
            r_comp   <= 3'd4;
            r_mips   <= 4'd0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BASE_W: r_base_w <= i_cfg_data;
                CFG_BASE_H: r_base_h <= i_cfg_data;
                CFG_COMP:   r_comp   <= i_cfg_data[2:0];
                CFG_MIPS:   r_mips   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Saturate the registers to their usable ranges.
    logic [8:0] bw, bh;
    logic [2:0] cc;
    logic [3:0] m;
    logic       mip;

    always_comb begin
        bw  = (r_base_w == 9'd0) ? 9'd1 : (r_base_w > 9'(MAX_DIM)) ? 9'(MAX_DIM) : r_base_w;
        bh  = (r_base_h == 9'd0) ? 9'd1 : (r_base_h > 9'(MAX_DIM)) ? 9'(MAX_DIM) : r_base_h;
        cc  = (r_comp == 3'd0) ? 3'd1 : (r_comp > 3'd4) ? 3'd4 : r_comp;
        m   = (r_mips > 4'(LEVELS)) ? 4'(LEVELS) : r_mips;
        mip = (r_mips != 4'd0);
    end

    // Whole pipeline advances together; stall only when the output buffer is full.
    logic [1:0] r_qcnt;
    logic       adv;
    assign adv = (r_qcnt != 2'd2);

    // ---------------- S: issue stage, one level per cycle unless the output buffer is full ----------------
    logic        r_sv, r_sph, r_s_cmd;
    logic [3:0]  r_s_lv;
    logic [7:0]  r_s_x, r_s_y;
    logic [31:0] r_s_texel;
    logic [15:0] r_s_u, r_s_v;
    logic [11:0] r_s_lod;

    logic [11:0] top_ld, ld;
    logic [3:0]  lo_lv, lv;
    logic [7:0]  lf, s_lf;
    logic        two, s_last, s_take, wr_ok;
    logic [8:0]  lw, lh, side;
    logic [7:0]  wm1, hm1, cx, cy, x1, y1, wu, wv;
    logic [23:0] px, py;

    always_comb begin
        top_ld = {m - 4'd1, 8'h00};
        ld     = (r_s_lod > top_ld) ? top_ld : r_s_lod;
        lo_lv  = mip ? ld[11:8] : 4'd0;
        lf     = mip ? ld[7:0] : 8'd0;
        two    = mip && (({1'b0, lo_lv} + 5'd1) < {1'b0, m}) && (lf != 8'd0);
        s_lf   = two ? lf : 8'd0;
        s_last = (r_s_cmd == CMD_WRITE) || !two || r_sph;
        lv     = r_sph ? lo_lv + 4'd1 : lo_lv;
        lw     = bw >> lv;
        lh     = bh >> lv;
        wm1    = (lw == 9'd0) ? 8'd0 : 8'(lw - 9'd1);
        hm1    = (lh == 9'd0) ? 8'd0 : 8'(lh - 9'd1);
        // map the wrapped fraction onto the level: frac * (size - 1)
        px     = {8'd0, r_s_u} * {16'd0, wm1};
        py     = {8'd0, r_s_v} * {16'd0, hm1};
        cx     = px[23:16];
        cy     = py[23:16];
        wu     = px[15:8];
        wv     = py[15:8];
        x1     = (cx < wm1) ? cx + 8'd1 : cx;
        y1     = (cy < hm1) ? cy + 8'd1 : cy;
        side   = 9'(MAX_DIM) >> r_s_lv;
        wr_ok  = (r_s_lv < 4'(LEVELS)) && ({1'b0, r_s_x} < side) && ({1'b0, r_s_y} < side);
    end

    assign s_axis_tready = adv && (!r_sv || s_last);
    assign s_take        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv  <= 1'b0;
            r_sph <= 1'b0;
        end else if (adv) begin
            if (s_take) begin
                r_sv  <= 1'b1;
                r_sph <= 1'b0;
            end else if (r_sv) begin
                if (s_last) r_sv <= 1'b0;
                else        r_sph <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_s_cmd   <= s_axis_tuser;
            r_s_lv    <= s_axis_tdata[3:0];
            r_s_x     <= s_axis_tdata[11:4];
            r_s_y     <= s_axis_tdata[19:12];
            r_s_texel <= s_axis_tdata[51:20];
            r_s_u     <= s_axis_tdata[67:52];
            r_s_v     <= s_axis_tdata[83:68];
            r_s_lod   <= s_axis_tdata[95:84];
        end
    end

    // ---------------- A: bank address stage ----------------
    logic        r_a_smp, r_a_wr, r_a_first, r_a_last, r_a_mip;
    logic [3:0]  r_a_lv;
    logic [7:0]  r_a_x0, r_a_x1, r_a_y0, r_a_y1, r_a_wu, r_a_wv, r_a_lf;
    logic [31:0] r_a_texel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_smp <= 1'b0;
            r_a_wr  <= 1'b0;
        end else if (adv) begin
            r_a_smp <= r_sv && (r_s_cmd == CMD_SAMPLE);
            r_a_wr  <= r_sv && (r_s_cmd == CMD_WRITE) && wr_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_s_cmd == CMD_WRITE) begin
                r_a_lv <= r_s_lv;
                r_a_x0 <= r_s_x;
                r_a_x1 <= r_s_x;
                r_a_y0 <= r_s_y;
                r_a_y1 <= r_s_y;
            end else begin
                r_a_lv <= lv;
                r_a_x0 <= cx;
                r_a_x1 <= x1;
                r_a_y0 <= cy;
                r_a_y1 <= y1;
            end
            r_a_wu    <= wu;
            r_a_wv    <= wv;
            r_a_first <= !r_sph;
            r_a_last  <= s_last;
            r_a_lf    <= s_lf;
            r_a_mip   <= mip;
            r_a_texel <= r_s_texel;
        end
    end

    // Bank {y[0], x[0]} holds the texel; within it, rows of half the level side.
    logic [2:0] a_sh;
    assign a_sh = (r_a_lv >= 4'(DIM_BITS - 1)) ? 3'd0 : 3'(4'(DIM_BITS - 1) - r_a_lv);

    logic [31:0] bank_q [4];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [7:0] bx, by;
        t_baddr     baddr;
        logic       bwe;

        always_comb begin
            bx    = (r_a_x0[0] == 1'(b)) ? r_a_x0 : r_a_x1;
            by    = (r_a_y0[0] == 1'(b >> 1)) ? r_a_y0 : r_a_y1;
            baddr = BANK_OFF[r_a_lv] + (t_baddr'(by[7:1]) << a_sh) + t_baddr'(bx[7:1]);
            bwe   = adv && r_a_wr && ({r_a_y0[0], r_a_x0[0]} == 2'(b));
        end

        mbts_ram #(
            .WIDTH (TEXEL_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (bwe),
            .i_waddr (baddr),
            .i_wdata (r_a_texel),
            .i_re    (adv),
            .i_raddr (baddr),
            .o_rdata (bank_q[b])
        );
    end

    // ---------------- D: bank data arrives, pick the quad ----------------
    logic       r_d_smp, r_d_first, r_d_last, r_d_mip;
    logic       r_d_x0p, r_d_x1p, r_d_y0p, r_d_y1p;
    logic [7:0] r_d_wu, r_d_wv, r_d_lf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_smp <= 1'b0;
        else if (adv) r_d_smp <= r_a_smp;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_first <= r_a_first;
            r_d_last  <= r_a_last;
            r_d_mip   <= r_a_mip;
            r_d_x0p   <= r_a_x0[0];
            r_d_x1p   <= r_a_x1[0];
            r_d_y0p   <= r_a_y0[0];
            r_d_y1p   <= r_a_y1[0];
            r_d_wu    <= r_a_wu;
            r_d_wv    <= r_a_wv;
            r_d_lf    <= r_a_lf;
        end
    end

    function automatic logic [15:0] f_mix8(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] w);
        logic [16:0] s;
        s = 17'(a) * (17'd256 - 17'(w)) + 17'(b) * 17'(w);
        return s[15:0];
    endfunction

    // Missing channels: 255 on the base path; colour 0 and alpha 255 on the mip path.
    function automatic logic [7:0] f_chan(input logic [31:0] word, input int c,
                                          input logic [2:0] ncc, input logic is_mip);
        logic [7:0] v;
        if (3'(c) < ncc)  v = word[8*c +: 8];
        else if (!is_mip) v = 8'hFF;
        else              v = (c == 3) ? 8'hFF : 8'h00;
        return v;
    endfunction

    logic [31:0] w00, w10, w01, w11;
    logic [15:0] h_top [4];
    logic [15:0] h_bot [4];

    always_comb begin
        w00 = bank_q[{r_d_y0p, r_d_x0p}];
        w10 = bank_q[{r_d_y0p, r_d_x1p}];
        w01 = bank_q[{r_d_y1p, r_d_x0p}];
        w11 = bank_q[{r_d_y1p, r_d_x1p}];
        for (int c = 0; c < 4; c++) begin
            h_top[c] = f_mix8(f_chan(w00, c, cc, r_d_mip), f_chan(w10, c, cc, r_d_mip), r_d_wu);
            h_bot[c] = f_mix8(f_chan(w01, c, cc, r_d_mip), f_chan(w11, c, cc, r_d_mip), r_d_wu);
        end
    end

    // ---------------- H: horizontal blend registered ----------------
    logic        r_h_smp, r_h_first, r_h_last;
    logic [7:0]  r_h_wv, r_h_lf;
    logic [15:0] r_h_top [4];
    logic [15:0] r_h_bot [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_h_smp <= 1'b0;
        else if (adv) r_h_smp <= r_d_smp;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_h_first <= r_d_first;
            r_h_last  <= r_d_last;
            r_h_wv    <= r_d_wv;
            r_h_lf    <= r_d_lf;
            r_h_top   <= h_top;
            r_h_bot   <= h_bot;
        end
    end

    // ---------------- V: vertical blend, Q.16 per channel ----------------
    logic        r_v_smp, r_v_first, r_v_last;
    logic [7:0]  r_v_lf;
    logic [23:0] r_v_acc [4];
    logic [23:0] v_acc [4];
    logic [24:0] v_sum;

    always_comb begin
        v_sum = '0;
        for (int c = 0; c < 4; c++) begin
            v_sum    = 25'(r_h_top[c]) * (25'd256 - 25'(r_h_wv)) + 25'(r_h_bot[c]) * 25'(r_h_wv);
            v_acc[c] = v_sum[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v_smp <= 1'b0;
        else if (adv) r_v_smp <= r_h_smp;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_v_first <= r_h_first;
            r_v_last  <= r_h_last;
            r_v_lf    <= r_h_lf;
            r_v_acc   <= v_acc;
        end
    end

    // ---------------- B: level blend ----------------
    // First level: part = acc * (256 - lf). Second level adds acc * lf. A single
    // level carries lf = 0, so it leaves as acc * 256.
    logic [32:0] r_part [4];
    logic [32:0] b_sum  [4];
    logic [8:0]  b_w;
    logic [63:0] b_res;
    logic        push, pop;

    always_comb begin
        b_w = r_v_first ? (9'd256 - 9'(r_v_lf)) : 9'(r_v_lf);
        for (int c = 0; c < 4; c++) begin
            b_sum[c] = (r_v_first ? 33'd0 : r_part[c]) + 33'(r_v_acc[c]) * 33'(b_w);
            b_res[16*c +: 16] = b_sum[c][31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_v_smp && r_v_first) begin
            r_part <= b_sum;
        end
    end

    // ---------------- two-entry output buffer ----------------
    logic [63:0] r_q0, r_q1;

    assign push = adv && r_v_smp && r_v_last;
    assign pop  = (r_qcnt != 2'd0) && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcnt <= 2'd0;
        end else begin
            r_qcnt <= r_qcnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_q0 <= r_q1;
        end
        if (push) begin
            if ((r_qcnt == 2'd0) || ((r_qcnt == 2'd1) && pop)) r_q0 <= b_res;
            else                                                r_q1 <= b_res;
        end
    end

    assign m_axis_tvalid = (r_qcnt != 2'd0);
    assign m_axis_tdata  = r_q0;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
    import mbts_pkg::*;

    typedef longint unsigned t_chan [4];

    // Texture model: shadow texel memory, register copies and the queue of expected filtered
    // samples. Texels live in a sparse map keyed by the flat mip-chain address.
    class texture_scoreboard;
        logic [8:0]  width_reg;
        logic [8:0]  height_reg;
        logic [2:0]  comp_reg;
        logic [3:0]  mips_reg;
        logic [31:0] texels [int];
        logic [63:0] pending_samples [$];
        int          errors;

        function new();
            width_reg  = 9'd1;
            height_reg = 9'd1;
            comp_reg   = 3'd4;
            mips_reg   = 4'd0;
            errors     = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [8:0] val);
            case (idx)
                CFG_BASE_W: width_reg  = val;
                CFG_BASE_H: height_reg = val;
                CFG_COMP:   comp_reg   = val[2:0];
                CFG_MIPS:   mips_reg   = val[3:0];
            endcase
        endfunction

        function int level_base(int lv);
            int acc;
            acc = 0;
            for (int k = 0; k < lv; k++) acc += (MAX_DIM >> k) * (MAX_DIM >> k);
            return acc;
        endfunction

        function int clamp_dim(int d);
            return (d < 1) ? 1 : (d > MAX_DIM) ? MAX_DIM : d;
        endfunction

        function void fetch(int lv, longint unsigned cx, longint unsigned cy, int lw, int lh,
                            bit mip, output t_chan ch);
            int          addr;
            int          cc;
            logic [31:0] word;
            cc = (comp_reg < 1) ? 1 : (comp_reg > 4) ? 4 : comp_reg;
            if (cx > lw - 1) cx = lw - 1;
            if (cy > lh - 1) cy = lh - 1;
            addr = level_base(lv) + int'(cy) * (MAX_DIM >> lv) + int'(cx);
            word = texels.exists(addr) ? texels[addr] : 32'd0;
            for (int c = 0; c < 4; c++) begin
                if (c < cc) ch[c] = word[8*c +: 8];
                else if (mip) ch[c] = (c == 3) ? 255 : 0;
                else ch[c] = 255;
            end
        endfunction

        // Bilinear blend of one level; result carries 16 fraction bits.
        function void filter_level(int lv, int lw, int lh, longint unsigned uu,
                                   longint unsigned vv, bit mip, output t_chan acc);
            longint unsigned px, py, cx, cy, wu, wv, upper, lower;
            t_chan t00, t10, t01, t11;
            px = uu * (lw - 1);
            py = vv * (lh - 1);
            cx = px >> 16;
            cy = py >> 16;
            wu = (px & 64'hFFFF) >> 8;
            wv = (py & 64'hFFFF) >> 8;
            fetch(lv, cx, cy, lw, lh, mip, t00);
            fetch(lv, cx + 1, cy, lw, lh, mip, t10);
            fetch(lv, cx, cy + 1, lw, lh, mip, t01);
            fetch(lv, cx + 1, cy + 1, lw, lh, mip, t11);
            for (int c = 0; c < 4; c++) begin
                upper  = t00[c] * (256 - wu) + t10[c] * wu;
                lower  = t01[c] * (256 - wu) + t11[c] * wu;
                acc[c] = upper * (256 - wv) + lower * wv;
            end
        endfunction

        // Note one accepted input beat: store a texel or queue the expected sample.
        function void note_beat(logic cmd, logic [95:0] d);
            int              lv, tx, ty, bw, bh, m, lo, hi, lw, lh;
            longint unsigned uu, vv, ld, lf;
            t_chan           acc0, acc1;
            logic [63:0]     res;
            if (cmd == CMD_WRITE) begin
                lv = d[3:0];
                tx = d[11:4];
                ty = d[19:12];
                if (lv < LEVELS && tx < (MAX_DIM >> lv) && ty < (MAX_DIM >> lv))
                    texels[level_base(lv) + ty * (MAX_DIM >> lv) + tx] = d[51:20];
                return;
            end
            bw = clamp_dim(width_reg);
            bh = clamp_dim(height_reg);
            uu = d[67:52];
            vv = d[83:68];
            if (mips_reg == 0) begin
                filter_level(0, bw, bh, uu, vv, 1'b0, acc0);
                for (int c = 0; c < 4; c++) res[16*c +: 16] = 16'((acc0[c] << 8) >> 16);
            end else begin
                m  = (mips_reg > LEVELS) ? LEVELS : mips_reg;
                ld = d[95:84];
                if (ld > (m - 1) * 256) ld = (m - 1) * 256;
                lo = int'(ld >> 8);
                lf = ld & 64'hFF;
                hi = (lo + 1 < m) ? lo + 1 : lo;
                lw = (bw >> lo) ? (bw >> lo) : 1;
                lh = (bh >> lo) ? (bh >> lo) : 1;
                filter_level(lo, lw, lh, uu, vv, 1'b1, acc0);
                if (hi == lo || lf == 0) begin
                    acc1 = acc0;
                    lf   = 0;
                end else begin
                    lw = (bw >> hi) ? (bw >> hi) : 1;
                    lh = (bh >> hi) ? (bh >> hi) : 1;
                    filter_level(hi, lw, lh, uu, vv, 1'b1, acc1);
                end
                for (int c = 0; c < 4; c++)
                    res[16*c +: 16] = 16'((acc0[c] * (256 - lf) + acc1[c] * lf) >> 16);
            end
            pending_samples = {pending_samples, res};
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
        endtask

        task check_beat(logic [63:0] got);
            logic [63:0] want;
            string       names [4];
            names = '{"red", "green", "blue", "alpha"};
            if (pending_samples.size() == 0) begin
                report("unexpected beat", got, 64'd0);
                return;
            end
            want = pending_samples.pop_front();
            for (int c = 0; c < 4; c++)
                if (got[16*c +: 16] !== want[16*c +: 16]) report(names[c], got, want);
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // level, tex_x, tex_y, texel_r/g/b/a, u_frac, v_frac, lod (lowest bit first)
    logic [95:0] s_axis_tdata = '0;
    // cmd
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // red, green, blue, alpha (lowest bit first)
    logic [63:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [8:0]  i_cfg_data = '0;

    texture_scoreboard sb = new();
    int  cycle_count = 0;
    bit  stall_request = 1'b0;
    bit  stall_done = 1'b0;

    always #5 i_clk = ~i_clk;

    mipmapped_bilinear_texture_sampler_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Abort on a hang; the slowest legal run is far below this.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Check every output beat against the oldest expected sample.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
    end

    // Receiver backpressure: mostly short ready or stalled stretches, some long stalls, some long
    // ready stretches, and one very long hold-off on request so the pipeline fills and blocks the input.
    initial begin
        int r;
        @(posedge i_rst_n);
        forever begin
            r = $urandom_range(0, 99);
            if (stall_request && !stall_done) begin
                m_axis_tready <= 1'b0;
                repeat (500) @(posedge i_clk);
                stall_done = 1'b1;
            end else if (r < 55) begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else if (r < 62) begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(100, 200)) @(posedge i_clk);
            end else if (r < 95) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(15, 60)) @(posedge i_clk);
            end
        end
    end

    int burst_left = 0;

    function int sender_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) burst_left = $urandom_range(50, 150);
        if (r < 60) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one beat, hold it until accepted, then idle for a random gap.
    task send_beat(logic cmd, logic [95:0] d);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_beat(cmd, d);
        gap = sender_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task send_texel(int lv, int x, int y, logic [31:0] rgba);
        logic [95:0] d;
        d = {$urandom, $urandom, $urandom};
        d[3:0]   = 4'(lv);
        d[11:4]  = 8'(x);
        d[19:12] = 8'(y);
        d[51:20] = rgba;
        send_beat(CMD_WRITE, d);
    endtask

    task send_sample(logic [15:0] u, logic [15:0] v, logic [11:0] lod);
        logic [95:0] d;
        d = {$urandom, $urandom, $urandom};
        d[67:52] = u;
        d[83:68] = v;
        d[95:84] = lod;
        send_beat(CMD_SAMPLE, d);
    endtask

    // Drain the block before touching registers; allow for the pipeline tail.
    task wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_samples.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task write_regs(logic [8:0] w, logic [8:0] h, logic [8:0] comp, logic [8:0] mips);
        logic [8:0] vals [4];
        vals = '{w, h, comp, mips};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= 2'(k);
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            sb.set_reg(t_cfg_idx'(k), vals[k]);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function int used_levels();
        if (sb.mips_reg == 0) return 1;
        return (sb.mips_reg > LEVELS) ? LEVELS : sb.mips_reg;
    endfunction

    function int lvl_dim(int base, int lv);
        int d;
        d = sb.clamp_dim(base) >> lv;
        return (d < 1) ? 1 : d;
    endfunction

    function logic [15:0] pick_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // One configuration phase: write each reachable texel not yet written, run a few corner samples
    // and three bad writes, then random samples, in-range rewrites and random writes, mostly ignored.
    task run_phase(int n_items);
        int          nl, lv, r;
        logic [11:0] lod_top;
        nl = used_levels();
        for (int l = 0; l < nl; l++)
            for (int y = 0; y < lvl_dim(sb.height_reg, l); y++)
                for (int x = 0; x < lvl_dim(sb.width_reg, l); x++)
                    if (!sb.texels.exists(sb.level_base(l) + y * (MAX_DIM >> l) + x))
                        send_texel(l, x, y, $urandom);
        lod_top = 12'((nl - 1) * 256);
        send_sample(16'h0000, 16'h0000, 12'h000);
        send_sample(16'hFFFF, 16'hFFFF, 12'hFFF);
        send_sample(16'h8000, 16'h7FFF, 12'h080);
        send_sample(16'hFFFF, 16'h0000, lod_top);
        send_sample(16'h0000, 16'hFFFF, 12'h100);
        send_sample(16'h1234, 16'hC0DE, 12'h1C0);
        send_texel(LEVELS, 0, 0, $urandom);
        send_texel(15, 255, 255, $urandom);
        send_texel(8, 1, 0, $urandom);
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                send_sample(pick_coord(), pick_coord(),
                            ($urandom_range(0, 7) == 0) ? 12'($urandom)
                                : 12'($urandom_range(0, lod_top + 255)));
            end else if (r < 88) begin
                lv = $urandom_range(0, nl - 1);
                send_texel(lv, $urandom_range(0, lvl_dim(sb.width_reg, lv) - 1),
                           $urandom_range(0, lvl_dim(sb.height_reg, lv) - 1), $urandom);
            end else begin
                send_texel($urandom_range(0, 15), $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom);
            end
        end
        wait_idle();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: a 1x1 base texture, four channels, no mips.
        run_phase(40);
        write_regs(9'd8, 9'd8, 9'd4, 9'd0);
        run_phase(130);
        write_regs(9'd2, 9'd64, 9'd1, 9'd4);
        run_phase(130);
        write_regs(9'd0, 9'd5, 9'd0, 9'd9);
        run_phase(80);
        // Oversized registers saturate: width 511 to 256, height 0 to 1, seven channels to four.
        write_regs(9'd511, 9'd0, 9'd7, 9'd0);
        run_phase(120);
        write_regs(9'd12, 9'd12, 9'd2, 9'd5);
        stall_request = 1'b1;
        run_phase(250);
        // Fifteen mips saturate to the nine physical levels.
        write_regs(9'd5, 9'd7, 9'd5, 9'd15);
        run_phase(160);
        write_regs(9'd32, 9'd1, 9'd3, 9'd1);
        run_phase(130);
        write_regs(9'd1, 9'd1, 9'd5, 9'd2);
        run_phase(80);

        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/mbts_pkg.sv
rtl/mbts_ram.sv
rtl/mipmapped_bilinear_texture_sampler_core.sv
verif/tb.sv
